FILE: rtl/core/gbk_text_page_wrapper_core_macros.svh
// ----------------------------------------------------------------------------
// gbk page wrapper assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef GBK_TEXT_PAGE_WRAPPER_CORE_MACROS_SVH
`define GBK_TEXT_PAGE_WRAPPER_CORE_MACROS_SVH

// same-cycle implication
`define GBK_ASSERT_IMPLY(label, ck, rn, pre, post) \
  label: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
    else $error("gbk check failed");

// next-cycle implication
`define GBK_ASSERT_NEXT(label, ck, rn, pre, post) \
  label: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
    else $error("gbk check failed");

`endif

FILE: rtl/core/gbk_pkg.sv
// ----------------------------------------------------------------------------
// gbk_pkg
// shared types, constants and helpers for the gbk page wrapper
// ----------------------------------------------------------------------------
package gbk_pkg;

  localparam int LINE_BYTES  = 32;
  localparam int PAGE_LINES  = 16;
  localparam int CHUNK_BYTES = 1024;
  localparam int WORD_DEPTH  = 32;
  localparam int WORD_LIMIT  = (LINE_BYTES < WORD_DEPTH) ? LINE_BYTES : WORD_DEPTH;
  localparam int Q_DEPTH     = 2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_UC_LO = 8'h40;
  localparam logic [7:0] CH_UC_HI = 8'h5b;
  localparam logic [7:0] CH_LC_LO = 8'h60;
  localparam logic [7:0] CH_LC_HI = 8'h7b;

  localparam logic KIND_CELL   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef enum logic [0:0] {
    REG_FILE_SIZE    = 1'b0,
    REG_START_OFFSET = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_BEGIN = 2'd0,
    MODE_TEXT  = 2'd1,
    MODE_END   = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    BC_LETTER,
    BC_LEAD,
    BC_CR,
    BC_LF,
    BC_TAB,
    BC_OTHER
  } byte_class_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BEGIN,
    ST_LONG,
    ST_FL_CHK,
    ST_FL_PUT,
    ST_BYTE,
    ST_BYTE_PUT,
    ST_END,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] byte_value;
  } gbk_in_t;

  typedef struct packed {
    logic        kind;
    logic [4:0]  line_index;
    logic [5:0]  column_index;
    logic [7:0]  cell_value;
    logic [12:0] page_bytes;
    logic        more_to_read;
    logic        last;
  } gbk_out_t;

  typedef struct packed {
    mode_t       mode;
    byte_class_t cls;
    logic [7:0]  value;
  } gbk_req_t;

  function automatic gbk_out_t mk_cell(logic [5:0] line, logic [5:0] col,
                                       logic [7:0] val, logic last);
    gbk_out_t o;
    o.kind         = KIND_CELL;
    o.line_index   = line[4:0];
    o.column_index = col;
    o.cell_value   = val;
    o.page_bytes   = '0;
    o.more_to_read = 1'b0;
    o.last         = last;
    return o;
  endfunction

  function automatic gbk_out_t mk_report(logic [12:0] pb, logic more);
    gbk_out_t o;
    o.kind         = KIND_REPORT;
    o.line_index   = '0;
    o.column_index = '0;
    o.cell_value   = '0;
    o.page_bytes   = pb;
    o.more_to_read = more;
    o.last         = 1'b1;
    return o;
  endfunction

endpackage

FILE: rtl/core/gbk_front.sv
// ----------------------------------------------------------------------------
// gbk_front
// accepts requests, classifies text bytes and queues them for the back end
// ----------------------------------------------------------------------------
module gbk_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gbk_pkg::gbk_in_t  in_data,
  output logic              req_valid,
  output gbk_pkg::gbk_req_t req,
  input  logic              req_pop
);
  import gbk_pkg::*;

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  gbk_req_t        q_r [Q_DEPTH];
  logic [PW-1:0]   rd_ptr_r, wr_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            push;
  logic            pop;
  gbk_req_t        entry;

  function automatic byte_class_t classify(logic [7:0] v);
    byte_class_t c;
    if ((v > CH_UC_LO && v < CH_UC_HI) || (v > CH_LC_LO && v < CH_LC_HI)) c = BC_LETTER;
    else if (v[7])        c = BC_LEAD;
    else if (v == CH_CR)  c = BC_CR;
    else if (v == CH_LF)  c = BC_LF;
    else if (v == CH_TAB) c = BC_TAB;
    else                  c = BC_OTHER;
    return c;
  endfunction

  assign in_ready  = (cnt_r != CW'(Q_DEPTH));
  assign req_valid = (cnt_r != '0);
  assign req       = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = req_pop && req_valid;

  always_comb begin
    entry.mode  = mode_t'(in_data.mode);
    entry.cls   = classify(in_data.byte_value);
    entry.value = in_data.byte_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= entry;
  end

endmodule

FILE: rtl/core/gbk_back.sv
// ----------------------------------------------------------------------------
// gbk_back
// layout sequencer: word buffer, line and column tracking, result register
// ----------------------------------------------------------------------------
module gbk_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  input  gbk_pkg::gbk_req_t req,
  output logic              req_pop,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output gbk_pkg::gbk_out_t out_data
);
  import gbk_pkg::*;

  state_t      state_r, state_nxt;
  logic [5:0]  line_r, line_nxt;
  logic [5:0]  col_r, col_nxt;
  logic [5:0]  wlen_r, wlen_nxt;
  logic [12:0] wstart_r, wstart_nxt;
  logic [12:0] consumed_r, consumed_nxt;
  logic        trail_r, trail_nxt;
  logic        skip_r, skip_nxt;
  logic        full_r, full_nxt;
  logic        long_r, long_nxt;
  logic        ll_cur_r, ll_cur_nxt;
  logic        flush_end_r, flush_end_nxt;
  logic [5:0]  i_r, i_nxt;
  logic [2:0]  blanks_r, blanks_nxt;
  logic [12:0] pb_r, pb_nxt;
  logic [12:0] idx_r, idx_nxt;
  logic [7:0]  cur_v_r, cur_v_nxt;
  byte_class_t cur_cls_r, cur_cls_nxt;
  logic [31:0] file_size_r, start_r;
  logic [7:0]  wbuf_r [WORD_DEPTH];
  logic        wbuf_we;
  gbk_out_t    out_r;
  logic        out_valid_r;

  logic        adv, emit, last_line, text_ok, skip_lf, ll_brk, ll_end, fl_brk, byte_brk;
  logic        is_brk_cls, more;
  logic [6:0]  col_ext, tab_over;
  logic [12:0] pos, cr_pb;
  logic [7:0]  ll_v;
  gbk_out_t    emit_data;

  assign adv       = !out_valid_r || out_ready;
  assign last_line = (line_r == 6'(PAGE_LINES - 1));
  assign col_ext   = {1'b0, col_r};
  assign text_ok   = !full_r && (consumed_r < 13'(CHUNK_BYTES));
  assign skip_lf   = skip_r && (req.cls == BC_LF);
  assign ll_brk    = (col_r >= 6'(LINE_BYTES));
  assign ll_end    = (6'(i_r + 6'd1) == wlen_r);
  assign fl_brk    = (col_ext + {1'b0, wlen_r}) > 7'(LINE_BYTES);
  assign tab_over  = col_ext + 7'd4 - 7'(LINE_BYTES);
  assign is_brk_cls = (cur_cls_r == BC_CR) || (cur_cls_r == BC_LF);
  assign pos       = ll_cur_r ? idx_r : 13'(wstart_r + 13'(i_r));
  assign ll_v      = ll_cur_r ? cur_v_r : wbuf_r[i_r[4:0]];
  assign cr_pb     = (13'(idx_r + 13'd2) > 13'(CHUNK_BYTES)) ? 13'(CHUNK_BYTES)
                                                             : 13'(idx_r + 13'd2);
  assign more      = ({1'b0, start_r} + 33'(pb_r)) < {1'b0, file_size_r};
  assign req_pop   = adv && (state_r == ST_IDLE) && req_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    unique case (cur_cls_r)
      BC_LEAD:      byte_brk = (col_ext + 7'd2) > 7'(LINE_BYTES);
      BC_TAB:       byte_brk = (col_ext + 7'd4) > 7'(LINE_BYTES);
      BC_CR, BC_LF: byte_brk = 1'b1;
      default:      byte_brk = (col_ext + 7'd1) > 7'(LINE_BYTES);
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    if (adv) begin
      unique case (state_r)
        ST_IDLE: begin
          if (req_valid) begin
            unique case (req.mode)
              MODE_BEGIN: state_nxt = ST_BEGIN;
              MODE_TEXT: begin
                if (text_ok && !trail_r && !skip_lf) begin
                  if (req.cls == BC_LETTER) begin
                    if (long_r || wlen_r >= 6'(WORD_LIMIT)) state_nxt = ST_LONG;
                  end else begin
                    state_nxt = (wlen_r != '0) ? ST_FL_CHK : ST_BYTE;
                  end
                end
              end
              MODE_END: begin
                if (!full_r) state_nxt = (wlen_r != '0) ? ST_FL_CHK : ST_END;
              end
              default: ;
            endcase
          end
        end
        ST_BEGIN:    if (i_r == 6'(PAGE_LINES - 1)) state_nxt = ST_IDLE;
        ST_LONG: begin
          if (ll_brk) begin
            if (last_line) state_nxt = ST_REPORT;
          end else if (ll_cur_r) begin
            state_nxt = ST_IDLE;
          end
        end
        ST_FL_CHK:   state_nxt = (fl_brk && last_line) ? ST_REPORT : ST_FL_PUT;
        ST_FL_PUT:   if (ll_end) state_nxt = flush_end_r ? ST_END : ST_BYTE;
        ST_BYTE: begin
          if (byte_brk && last_line) state_nxt = ST_REPORT;
          else if (is_brk_cls)       state_nxt = ST_IDLE;
          else                       state_nxt = ST_BYTE_PUT;
        end
        ST_BYTE_PUT: begin
          if (cur_cls_r != BC_TAB || blanks_r == 3'd1) state_nxt = ST_IDLE;
        end
        ST_END:      state_nxt = ST_REPORT;
        ST_REPORT:   state_nxt = ST_IDLE;
        default:     state_nxt = ST_IDLE;
      endcase
    end
  end

  // datapath and results
  always_comb begin
    line_nxt      = line_r;
    col_nxt       = col_r;
    wlen_nxt      = wlen_r;
    wstart_nxt    = wstart_r;
    consumed_nxt  = consumed_r;
    trail_nxt     = trail_r;
    skip_nxt      = skip_r;
    full_nxt      = full_r;
    long_nxt      = long_r;
    ll_cur_nxt    = ll_cur_r;
    flush_end_nxt = flush_end_r;
    i_nxt         = i_r;
    blanks_nxt    = blanks_r;
    pb_nxt        = pb_r;
    idx_nxt       = idx_r;
    cur_v_nxt     = cur_v_r;
    cur_cls_nxt   = cur_cls_r;
    wbuf_we       = 1'b0;
    emit          = 1'b0;
    emit_data     = mk_cell(line_r, col_r, 8'h00, 1'b0);
    if (adv) begin
      unique case (state_r)
        ST_IDLE: begin
          if (req_valid) begin
            unique case (req.mode)
              MODE_BEGIN: begin
                line_nxt     = '0;
                col_nxt      = '0;
                wlen_nxt     = '0;
                wstart_nxt   = '0;
                consumed_nxt = '0;
                trail_nxt    = 1'b0;
                skip_nxt     = 1'b0;
                full_nxt     = 1'b0;
                long_nxt     = 1'b0;
                i_nxt        = '0;
              end
              MODE_TEXT: begin
                if (text_ok) begin
                  consumed_nxt = 13'(consumed_r + 13'd1);
                  idx_nxt      = consumed_r;
                  cur_v_nxt    = req.value;
                  cur_cls_nxt  = req.cls;
                  if (trail_r) begin
                    trail_nxt = 1'b0;
                    emit      = 1'b1;
                    emit_data = mk_cell(line_r, col_r, req.value, 1'b1);
                    col_nxt   = 6'(col_r + 6'd1);
                  end else if (!skip_lf) begin
                    skip_nxt = 1'b0;
                    if (req.cls == BC_LETTER) begin
                      if (long_r) begin
                        ll_cur_nxt = 1'b1;
                      end else if (wlen_r < 6'(WORD_LIMIT)) begin
                        if (wlen_r == '0) wstart_nxt = consumed_r;
                        wbuf_we  = 1'b1;
                        wlen_nxt = 6'(wlen_r + 6'd1);
                      end else begin
                        ll_cur_nxt = 1'b0;
                        i_nxt      = '0;
                      end
                    end else begin
                      long_nxt      = 1'b0;
                      flush_end_nxt = 1'b0;
                    end
                  end else begin
                    skip_nxt = 1'b0;
                  end
                end
              end
              MODE_END: begin
                if (!full_r) begin
                  long_nxt      = 1'b0;
                  flush_end_nxt = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        ST_BEGIN: begin
          emit      = 1'b1;
          emit_data = mk_cell(i_r, 6'd0, 8'h00, i_r == 6'(PAGE_LINES - 1));
          i_nxt     = 6'(i_r + 6'd1);
        end
        ST_LONG: begin
          emit = 1'b1;
          if (ll_brk) begin
            emit_data = mk_cell(line_r, col_r, 8'h00, 1'b0);
            line_nxt  = 6'(line_r + 6'd1);
            col_nxt   = '0;
            pb_nxt    = pos;
          end else begin
            emit_data = mk_cell(line_r, col_r, ll_v, ll_cur_r);
            col_nxt   = 6'(col_r + 6'd1);
            if (!ll_cur_r) begin
              i_nxt = 6'(i_r + 6'd1);
              if (ll_end) begin
                ll_cur_nxt = 1'b1;
                wlen_nxt   = '0;
                long_nxt   = 1'b1;
              end
            end
          end
        end
        ST_FL_CHK: begin
          i_nxt = '0;
          if (fl_brk) begin
            emit      = 1'b1;
            emit_data = mk_cell(line_r, col_r, 8'h00, 1'b0);
            line_nxt  = 6'(line_r + 6'd1);
            col_nxt   = '0;
            pb_nxt    = wstart_r;
          end
        end
        ST_FL_PUT: begin
          emit      = 1'b1;
          emit_data = mk_cell(line_r, col_r, wbuf_r[i_r[4:0]], 1'b0);
          col_nxt   = 6'(col_r + 6'd1);
          i_nxt     = 6'(i_r + 6'd1);
          if (ll_end) wlen_nxt = '0;
        end
        ST_BYTE: begin
          blanks_nxt = 3'd4;
          if (byte_brk) begin
            emit      = 1'b1;
            emit_data = mk_cell(line_r, col_r, 8'h00, is_brk_cls && !last_line);
            line_nxt  = 6'(line_r + 6'd1);
            col_nxt   = '0;
            if (cur_cls_r == BC_TAB) blanks_nxt = tab_over[2:0];
            if (cur_cls_r == BC_CR)      pb_nxt = cr_pb;
            else if (cur_cls_r == BC_LF) pb_nxt = 13'(idx_r + 13'd1);
            else                         pb_nxt = idx_r;
            if (cur_cls_r == BC_CR && !last_line) skip_nxt = 1'b1;
          end
        end
        ST_BYTE_PUT: begin
          emit    = 1'b1;
          col_nxt = 6'(col_r + 6'd1);
          if (cur_cls_r == BC_TAB) begin
            emit_data  = mk_cell(line_r, col_r, CH_SPACE, blanks_r == 3'd1);
            blanks_nxt = 3'(blanks_r - 3'd1);
          end else begin
            emit_data = mk_cell(line_r, col_r, cur_v_r, 1'b1);
            if (cur_cls_r == BC_LEAD) trail_nxt = 1'b1;
          end
        end
        ST_END: begin
          emit      = 1'b1;
          emit_data = mk_cell(line_r, col_r, 8'h00, 1'b0);
          trail_nxt = 1'b0;
          skip_nxt  = 1'b0;
          pb_nxt    = consumed_r;
        end
        ST_REPORT: begin
          emit      = 1'b1;
          emit_data = mk_report(pb_r, more);
          full_nxt  = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      line_r      <= '0;
      col_r       <= '0;
      wlen_r      <= '0;
      wstart_r    <= '0;
      consumed_r  <= '0;
      trail_r     <= 1'b0;
      skip_r      <= 1'b0;
      full_r      <= 1'b0;
      long_r      <= 1'b0;
      ll_cur_r    <= 1'b0;
      flush_end_r <= 1'b0;
      i_r         <= '0;
      out_valid_r <= 1'b0;
      file_size_r <= '0;
      start_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      line_r      <= line_nxt;
      col_r       <= col_nxt;
      wlen_r      <= wlen_nxt;
      wstart_r    <= wstart_nxt;
      consumed_r  <= consumed_nxt;
      trail_r     <= trail_nxt;
      skip_r      <= skip_nxt;
      full_r      <= full_nxt;
      long_r      <= long_nxt;
      ll_cur_r    <= ll_cur_nxt;
      flush_end_r <= flush_end_nxt;
      i_r         <= i_nxt;
      if (emit)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == REG_FILE_SIZE) file_size_r <= cfg_data;
        else                            start_r     <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    blanks_r  <= blanks_nxt;
    pb_r      <= pb_nxt;
    idx_r     <= idx_nxt;
    cur_v_r   <= cur_v_nxt;
    cur_cls_r <= cur_cls_nxt;
    if (emit)    out_r <= emit_data;
    if (wbuf_we) wbuf_r[wlen_r[4:0]] <= req.value;
  end

endmodule

FILE: rtl/core/gbk_text_page_wrapper_core.sv
// ----------------------------------------------------------------------------
// gbk_text_page_wrapper_core
// greedy word-wrap layout of a gbk byte stream into one text page
// ----------------------------------------------------------------------------
//  port group | dir | handshake           | payload
//  in_        | in  | in_valid/in_ready   | gbk_in_t  (mode, byte_value)
//  out_       | out | out_valid/out_ready | gbk_out_t (cell write or report)
//  cfg_       | in  | cfg_valid/cfg_ready | cfg_index, cfg_data (always ready)
//
//  at most one result per cycle from the back-end sequencer, which stalls while
//  the result register is held; begin writes one cell per page line; a pending
//  word of letters is laid out before the byte that ends it; a two-entry
//  request queue lets the front keep taking requests while the sequencer works
//  synchronous active-low reset; the word buffer is not cleared
module gbk_text_page_wrapper_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gbk_pkg::gbk_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output gbk_pkg::gbk_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import gbk_pkg::*;

  gbk_req_t req;
  logic     req_valid;
  logic     req_pop;

  assign cfg_ready = 1'b1;

  gbk_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop)
  );

  gbk_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/core/gbk_checker.sv
// ----------------------------------------------------------------------------
// gbk_checker
// port-level checks for the gbk page wrapper, bound to the top level
// ----------------------------------------------------------------------------
`include "gbk_text_page_wrapper_core_macros.svh"

module gbk_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input gbk_pkg::gbk_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input gbk_pkg::gbk_out_t out_data,
  input logic              cfg_valid,
  input logic              cfg_ready,
  input logic [0:0]        cfg_index,
  input logic [31:0]       cfg_data
);
  import gbk_pkg::*;

  `GBK_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_data))
  `GBK_ASSERT_IMPLY(a_report_shape, clk, rst_n,
    out_valid && out_data.kind == KIND_REPORT,
    out_data.last && out_data.line_index == '0 && out_data.column_index == '0
      && out_data.cell_value == '0)
  `GBK_ASSERT_IMPLY(a_cell_shape, clk, rst_n,
    out_valid && out_data.kind == KIND_CELL,
    out_data.page_bytes == '0 && !out_data.more_to_read)
  `GBK_ASSERT_IMPLY(a_cell_range, clk, rst_n,
    out_valid && out_data.kind == KIND_CELL,
    out_data.column_index <= 6'(LINE_BYTES)
      && out_data.line_index <= 5'(PAGE_LINES - 1))

endmodule

bind gbk_text_page_wrapper_core gbk_checker u_gbk_checker (.*);

FILE: sim/gbk_text_page_wrapper_core_test.sv
// ----------------------------------------------------------------------------
// gbk_text_page_wrapper_core_test
// self-checking bench: text pages pushed through the wrapper, every cell
// write and page report checked in order against a behavioral predictor
// ----------------------------------------------------------------------------
module gbk_text_page_wrapper_core_test;
  import gbk_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  gbk_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  gbk_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  gbk_text_page_wrapper_core uut (.*);

  always #2 clk = ~clk;

  gbk_in_t pending_reqs[$];
  gbk_out_t expected_cells[$];
  int send_idle_pct = 28;
  int recv_idle_pct = 88;
  int hold_cycles = 0;
  int errors = 0;
  int cycle_count = 0;
  int results_seen = 0;
  int reports_seen = 0;
  int reqs_sent = 0;
  bit in_taken = 1'b0;

  // predictor state
  logic [31:0] p_file_size, p_start_offset;
  int p_line, p_col, p_wlen, p_wstart, p_consumed;
  logic [7:0] p_wbuf[WORD_DEPTH];
  bit p_trail, p_skip, p_full, p_long;
  gbk_out_t step_res[$];

  function automatic void push_cell(int line, int col, int val);
    gbk_out_t o;
    o = '0;
    o.kind = KIND_CELL;
    o.line_index = line[4:0];
    o.column_index = col[5:0];
    o.cell_value = val[7:0];
    step_res.push_back(o);
  endfunction

  function automatic void push_report(int pb);
    gbk_out_t o;
    longint sum;
    o = '0;
    sum = longint'(p_start_offset) + pb;
    o.kind = KIND_REPORT;
    o.page_bytes = pb[12:0];
    o.more_to_read = sum < longint'(p_file_size);
    step_res.push_back(o);
    p_full = 1;
  endfunction

  function automatic void put_byte(int v);
    push_cell(p_line, p_col, v);
    p_col++;
  endfunction

  function automatic bit break_line();
    push_cell(p_line, p_col, 0);
    p_line++;
    p_col = 0;
    return p_line >= PAGE_LINES;
  endfunction

  function automatic bit long_put(int v, int pos);
    if (p_col >= LINE_BYTES) begin
      if (break_line()) begin
        push_report(pos);
        return 1;
      end
    end
    put_byte(v);
    return 0;
  endfunction

  function automatic bit flush_word();
    int n;
    n = p_wlen;
    if (n == 0) return 0;
    p_wlen = 0;
    if (p_col + n > LINE_BYTES) begin
      if (break_line()) begin
        push_report(p_wstart);
        return 1;
      end
    end
    for (int i = 0; i < n; i++) put_byte(p_wbuf[i]);
    return 0;
  endfunction

  function automatic void layout_byte(logic [7:0] v);
    int idx, blanks;
    bit letter;
    if (p_consumed >= CHUNK_BYTES) return;
    idx = p_consumed++;
    if (p_trail) begin
      p_trail = 0;
      put_byte(v);
      return;
    end
    if (p_skip) begin
      p_skip = 0;
      if (v == CH_LF) return;
    end
    letter = (v > CH_UC_LO && v < CH_UC_HI) || (v > CH_LC_LO && v < CH_LC_HI);
    if (letter) begin
      if (p_long) begin
        void'(long_put(v, idx));
        return;
      end
      if (p_wlen < WORD_LIMIT) begin
        if (p_wlen == 0) p_wstart = idx;
        p_wbuf[p_wlen] = v;
        p_wlen++;
        return;
      end
      for (int i = 0; i < p_wlen; i++)
        if (long_put(p_wbuf[i], p_wstart + i)) return;
      p_wlen = 0;
      p_long = 1;
      void'(long_put(v, idx));
      return;
    end
    p_long = 0;
    if (flush_word()) return;
    if (v[7]) begin
      if (p_col + 2 > LINE_BYTES && break_line()) begin
        push_report(idx);
        return;
      end
      put_byte(v);
      p_trail = 1;
    end else if (v == CH_CR) begin
      if (break_line()) begin
        push_report((idx + 2 > CHUNK_BYTES) ? CHUNK_BYTES : idx + 2);
        return;
      end
      p_skip = 1;
    end else if (v == CH_LF) begin
      if (break_line()) push_report(idx + 1);
    end else if (v == CH_TAB) begin
      blanks = 4;
      if (p_col + 4 > LINE_BYTES) begin
        blanks = p_col + 4 - LINE_BYTES;
        if (break_line()) begin
          push_report(idx);
          return;
        end
      end
      for (int i = 0; i < blanks; i++) put_byte(CH_SPACE);
    end else begin
      if (p_col + 1 > LINE_BYTES && break_line()) begin
        push_report(idx);
        return;
      end
      put_byte(v);
    end
  endfunction

  function automatic void clear_page();
    p_line = 0;
    p_col = 0;
    p_wlen = 0;
    p_wstart = 0;
    p_consumed = 0;
    p_trail = 0;
    p_skip = 0;
    p_full = 0;
    p_long = 0;
  endfunction

  function automatic void predict_request(gbk_in_t req);
    step_res.delete();
    case (mode_t'(req.mode))
      MODE_BEGIN: begin
        clear_page();
        for (int j = 0; j < PAGE_LINES; j++) push_cell(j, 0, 0);
      end
      MODE_TEXT: begin
        if (!p_full) layout_byte(req.byte_value);
      end
      MODE_END: begin
        if (!p_full) begin
          p_long = 0;
          if (!flush_word()) begin
            p_trail = 0;
            p_skip = 0;
            push_cell(p_line, p_col, 0);
            push_report(p_consumed);
          end
        end
      end
      default: ;
    endcase
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) expected_cells.push_back(step_res[i]);
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_taken) begin
      end else if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_taken <= 1'b0;
      end else begin
        in_valid <= 1'b0;
        in_taken <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= $urandom_range(99) >= recv_idle_pct;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && in_valid && in_ready) begin
      predict_request(in_data);
      reqs_sent <= reqs_sent + 1;
      in_taken <= 1'b1;
    end
    if (rst_n && out_valid && out_ready) begin
      gbk_out_t e;
      results_seen <= results_seen + 1;
      if (expected_cells.size() == 0) begin
        $error("unexpected result %p", out_data);
        errors++;
      end else begin
        e = expected_cells.pop_front();
        if (out_data.kind == KIND_REPORT) reports_seen <= reports_seen + 1;
        if (out_data.kind !== e.kind) begin
          $error("kind exp %0d got %0d", e.kind, out_data.kind); errors++;
        end
        if (out_data.line_index !== e.line_index) begin
          $error("line_index exp %0d got %0d", e.line_index, out_data.line_index);
          errors++;
        end
        if (out_data.column_index !== e.column_index) begin
          $error("column_index exp %0d got %0d", e.column_index, out_data.column_index);
          errors++;
        end
        if (out_data.cell_value !== e.cell_value) begin
          $error("cell_value exp %0h got %0h", e.cell_value, out_data.cell_value);
          errors++;
        end
        if (out_data.page_bytes !== e.page_bytes) begin
          $error("page_bytes exp %0d got %0d", e.page_bytes, out_data.page_bytes);
          errors++;
        end
        if (out_data.more_to_read !== e.more_to_read) begin
          $error("more_to_read exp %0d got %0d", e.more_to_read, out_data.more_to_read);
          errors++;
        end
        if (out_data.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_data.last); errors++;
        end
      end
    end
    if (cycle_count > 2000000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic void add_req(mode_t m, logic [7:0] v);
    gbk_in_t r;
    r.mode = m;
    r.byte_value = v;
    pending_reqs.push_back(r);
  endfunction

  function automatic logic [7:0] rand_letter();
    return $urandom_range(1) ? 8'(8'h41 + $urandom_range(25)) : 8'(8'h61 + $urandom_range(25));
  endfunction

  // realistic page with random text mix
  function automatic void add_page(int nbytes);
    int k, w;
    add_req(MODE_BEGIN, 8'($urandom));
    k = 0;
    while (k < nbytes) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          w = ($urandom_range(15) == 0) ? $urandom_range(33, 40) : $urandom_range(1, 8);
          for (int i = 0; i < w; i++) add_req(MODE_TEXT, rand_letter());
          k += w;
        end
        4: begin add_req(MODE_TEXT, 8'($urandom_range(128, 255)));
          add_req(MODE_TEXT, 8'($urandom)); k += 2; end
        5: begin add_req(MODE_TEXT, CH_CR);
          if ($urandom_range(1)) add_req(MODE_TEXT, CH_LF); k += 2; end
        6: begin add_req(MODE_TEXT, CH_LF); k++; end
        7: begin add_req(MODE_TEXT, CH_TAB); k++; end
        8: begin add_req(MODE_TEXT, CH_SPACE); k++; end
        default: begin
          add_req(mode_t'($urandom_range(3) == 0 ? 3 : 1), 8'($urandom)); k++;
        end
      endcase
    end
    if ($urandom_range(3) != 0) add_req(MODE_END, 8'($urandom));
  endfunction

  task automatic wait_drained();
    int guard;
    guard = 0;
    while ((pending_reqs.size() > 0 || in_valid || expected_cells.size() > 0) &&
           guard < 400000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_FILE_SIZE) p_file_size = val;
    else p_start_offset = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    p_file_size = 0;
    p_start_offset = 0;
    clear_page();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, lead/trail, cr-lf, tabs, long word, mode 3
    write_reg(REG_FILE_SIZE, 32'hffff_ffff);
    write_reg(REG_START_OFFSET, 32'h0);
    add_req(MODE_BEGIN, 8'h00);
    add_req(MODE_TEXT, 8'h00);
    add_req(MODE_TEXT, 8'hff);
    add_req(MODE_TEXT, 8'h0d);
    add_req(MODE_TEXT, CH_CR);
    add_req(MODE_TEXT, CH_LF);
    add_req(MODE_TEXT, CH_CR);
    add_req(MODE_TEXT, 8'h41);
    add_req(MODE_TEXT, CH_TAB);
    add_req(MODE_NONE, 8'hff);
    for (int i = 0; i < 34; i++) add_req(MODE_TEXT, 8'h7a);
    add_req(MODE_TEXT, CH_LF);
    for (int i = 0; i < 7; i++) add_req(MODE_TEXT, CH_TAB);
    add_req(MODE_TEXT, 8'h80);
    add_req(MODE_END, 8'h00);
    add_req(MODE_TEXT, 8'h5a);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin send_idle_pct = 88; recv_idle_pct = 28; end
      if (phase == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      case (phase)
        0: begin write_reg(REG_FILE_SIZE, 32'h0); write_reg(REG_START_OFFSET, 32'hffff_ffff); end
        1: begin write_reg(REG_FILE_SIZE, 32'd300); write_reg(REG_START_OFFSET, 32'd100); end
        default: begin write_reg(REG_FILE_SIZE, $urandom); write_reg(REG_START_OFFSET, $urandom_range(400)); end
      endcase
      if (phase == 2) hold_cycles = 300;
      for (int p = 0; p < 2; p++) add_page($urandom_range(20, 80));
      if (phase == 2) add_page(160);
      wait_drained();
    end
    // one page of bare line feeds that fills up, later bytes dropped
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_req(MODE_BEGIN, 8'h00);
    for (int i = 0; i < 20; i++) add_req(MODE_TEXT, CH_LF);
    add_req(MODE_END, 8'h00);
    wait_drained();

    $display("sent %0d requests, checked %0d results including %0d page reports",
             reqs_sent, results_seen, reports_seen);
    if (errors == 0 && expected_cells.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
